[rtl/rmsp_pkg.sv]
// Shared types and constants for the repeat model symbol predictor.
package rmsp_pkg;

  localparam int CNT_W      = 32;
  localparam int FRAC_W     = 8;
  localparam int ALPHA_W    = 16;
  localparam int DIV_W      = CNT_W + FRAC_W + 1;
  localparam int BASE_W     = 2;
  localparam int PROB_W     = 16;
  localparam int OTHER_W    = 15;
  localparam int POS_OUT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd16;
  localparam logic [BASE_W-1:0]  BASE_MAX    = 2'd3;
  localparam logic [CNT_W-1:0]   COUNT_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE = 2'd0,
    CFG_ALPHA   = 2'd1,
    CFG_START   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_NORM,
    DIV_HALF,
    DIV_SAT
  } div_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic vld;
    logic qbit;
    logic last;
  } qbit_t;

endpackage

[rtl/rmsp_prob_div.sv]
// Restoring divider that emits one probability bit per cycle, most significant first.
module rmsp_prob_div #(
  parameter int PROB_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rmsp_pkg::DIV_W-1:0]    num_i,
  input  logic [rmsp_pkg::DIV_W-1:0]    den_i,
  output rmsp_pkg::qbit_t               qbit_o
);

  localparam int DivW = rmsp_pkg::DIV_W;
  localparam int CntW = $clog2(PROB_BITS);

  logic                busy_q;
  logic [CntW-1:0]     cnt_q;
  rmsp_pkg::div_mode_e mode_q;
  logic [DivW-1:0]     rem_q;
  logic [DivW-1:0]     rem_d;
  logic [DivW-1:0]     den_q;
  logic [DivW:0]       rem2;
  logic [DivW:0]       diff;
  logic                ge;
  logic                last;
  logic                qb;

  always_comb begin
    rem2 = {rem_q, 1'b0};
    diff = rem2 - {1'b0, den_q};
    ge   = rem2 >= {1'b0, den_q};
    last = cnt_q == CntW'(PROB_BITS - 1);
    rem_d = ge ? diff[DivW-1:0] : rem2[DivW-1:0];
    case (mode_q)
      rmsp_pkg::DIV_NORM: qb = ge;
      rmsp_pkg::DIV_HALF: qb = (cnt_q == '0);
      rmsp_pkg::DIV_SAT:  qb = 1'b1;
      default:            qb = ge;
    endcase
  end

  assign qbit_o.vld  = busy_q;
  assign qbit_o.qbit = qb;
  assign qbit_o.last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= rmsp_pkg::DIV_NORM;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      if (den_i == '0) begin
        mode_q <= rmsp_pkg::DIV_HALF;
      end else if (num_i >= den_i) begin
        mode_q <= rmsp_pkg::DIV_SAT;
      end else begin
        mode_q <= rmsp_pkg::DIV_NORM;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

endmodule

[rtl/rmsp_div3.sv]
// Serial collector of the probability bits and bit-serial division of its complement by three.
module rmsp_div3 #(
  parameter int PROB_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmsp_pkg::qbit_t      qbit_i,
  output logic                 done_o,
  output logic [PROB_BITS-1:0] prob_o,
  output logic [PROB_BITS-1:0] other_o
);

  localparam logic [2:0] Three = 3'd3;

  logic                 first_q;
  logic                 done_q;
  logic [1:0]           r_q;
  logic [1:0]           r_d;
  logic [PROB_BITS-1:0] p_q;
  logic [PROB_BITS-1:0] q3_q;
  logic [2:0]           t;
  logic [2:0]           t_sub;
  logic                 qd;

  // The complement of the probability is divided by three; a final remainder
  // of two rounds the quotient up, which accounts for the missing one.
  always_comb begin
    t     = {(first_q ? 2'b00 : r_q), ~qbit_i.qbit};
    qd    = t >= Three;
    t_sub = t - Three;
    r_d   = qd ? t_sub[1:0] : t[1:0];
  end

  assign done_o  = done_q;
  assign prob_o  = p_q;
  assign other_o = q3_q + PROB_BITS'(r_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      done_q  <= 1'b0;
      r_q     <= '0;
    end else begin
      done_q <= qbit_i.vld & qbit_i.last;
      if (qbit_i.vld) begin
        first_q <= qbit_i.last;
        r_q     <= r_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (qbit_i.vld) begin
      p_q  <= {p_q[PROB_BITS-2:0], qbit_i.qbit};
      q3_q <= {q3_q[PROB_BITS-2:0], qd};
    end
  end

endmodule

[rtl/repeat_model_symbol_predictor_core.sv]
// Top level of the repeat model symbol predictor: control, counts, position and result word.
// Each input word gives the reference base and the actual base. The block predicts the
// reference base (complemented in reverse-complement mode), gives its probability
// (256 hits + alpha) / (256 tries + 2 alpha) and the probability of each other base,
// then counts the try and the hit and steps the position. One word is processed at a
// time: no new word is accepted until the last result is committed to the output
// register, and the radix-2 divider produces one probability bit per cycle. A finished
// result waits in the output register while the next word is being processed. Writing
// start_position loads the position and clears both counts; the user must write
// configuration only while the block is idle, which the block itself does not enforce.
module repeat_model_symbol_predictor_core #(
  parameter int ADDR_WIDTH = 32,
  parameter int PROB_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rmsp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rmsp_pkg::BASE_W-1:0]         reference_base_i,
  input  logic [rmsp_pkg::BASE_W-1:0]         actual_base_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rmsp_pkg::BASE_W-1:0]         predicted_base_o,
  output logic [rmsp_pkg::PROB_W-1:0]         predicted_probability_o,
  output logic [rmsp_pkg::OTHER_W-1:0]        other_probability_o,
  output logic                                hit_o,
  output logic [rmsp_pkg::POS_OUT_W-1:0]      next_position_o
);

  localparam int DivW   = rmsp_pkg::DIV_W;
  localparam int CntW   = rmsp_pkg::CNT_W;
  localparam int FracW  = rmsp_pkg::FRAC_W;
  localparam int AlphaW = rmsp_pkg::ALPHA_W;
  localparam int BaseW  = rmsp_pkg::BASE_W;
  localparam int DataW  = rmsp_pkg::CFG_DATA_W;
  localparam int PosOW  = rmsp_pkg::POS_OUT_W;
  localparam int ProbW  = rmsp_pkg::PROB_W;
  localparam int OthW   = rmsp_pkg::OTHER_W;

  rmsp_pkg::state_e      state_q;
  rmsp_pkg::state_e      state_d;
  logic                  in_ready;
  logic                  start;
  logic                  commit;

  logic                  rc_q;
  logic [AlphaW-1:0]     alpha_q;
  logic [ADDR_WIDTH-1:0] pos_q;
  logic [ADDR_WIDTH-1:0] pos_d;
  logic [CntW-1:0]       hit_cnt_q;
  logic [CntW-1:0]       try_cnt_q;

  logic [BaseW-1:0]      pred_q;
  logic                  hit_q;
  logic [BaseW-1:0]      pred;

  logic [DivW-1:0]       num;
  logic [DivW-1:0]       den;

  rmsp_pkg::qbit_t       qbit;
  logic                  div_done;
  logic [PROB_BITS-1:0]  prob;
  logic [PROB_BITS-1:0]  other;

  logic [ADDR_WIDTH+DataW-1:0]    start_ext;
  logic [ADDR_WIDTH+PosOW-1:0]    pos_ext;
  logic [PROB_BITS+ProbW-1:0]     prob_ext;
  logic [PROB_BITS+ProbW-1:0]     other_ext;

  logic                  out_valid_q;
  logic [BaseW-1:0]      out_pred_q;
  logic [ProbW-1:0]      out_prob_q;
  logic [OthW-1:0]       out_other_q;
  logic                  out_hit_q;
  logic [PosOW-1:0]      out_pos_q;

  assign pred = rc_q ? (rmsp_pkg::BASE_MAX - reference_base_i) : reference_base_i;

  assign num = DivW'({hit_cnt_q, FracW'(0)}) + DivW'(alpha_q);
  assign den = DivW'({try_cnt_q, FracW'(0)}) + DivW'({alpha_q, 1'b0});

  assign pos_d     = rc_q ? (pos_q - ADDR_WIDTH'(1)) : (pos_q + ADDR_WIDTH'(1));
  assign start_ext = {ADDR_WIDTH'(0), cfg_data_i};
  assign pos_ext   = {PosOW'(0), pos_d};
  assign prob_ext  = {ProbW'(0), prob};
  assign other_ext = {ProbW'(0), other};

  rmsp_prob_div #(
    .PROB_BITS(PROB_BITS)
  ) u_prob_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .num_i  (num),
    .den_i  (den),
    .qbit_o (qbit)
  );

  rmsp_div3 #(
    .PROB_BITS(PROB_BITS)
  ) u_div3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qbit_i (qbit),
    .done_o (div_done),
    .prob_o (prob),
    .other_o(other)
  );

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    start    = 1'b0;
    commit   = 1'b0;
    case (state_q)
      rmsp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          start   = 1'b1;
          state_d = rmsp_pkg::ST_RUN;
        end
      end
      rmsp_pkg::ST_RUN: begin
        if (div_done) begin
          state_d = rmsp_pkg::ST_FIN;
        end
      end
      rmsp_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = rmsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmsp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q      <= 1'b0;
      alpha_q   <= rmsp_pkg::ALPHA_RESET;
      pos_q     <= '0;
      hit_cnt_q <= '0;
      try_cnt_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rmsp_pkg::CFG_REVERSE: begin
          rc_q <= cfg_data_i[0];
        end
        rmsp_pkg::CFG_ALPHA: begin
          alpha_q <= cfg_data_i[AlphaW-1:0];
        end
        rmsp_pkg::CFG_START: begin
          pos_q     <= start_ext[ADDR_WIDTH-1:0];
          hit_cnt_q <= '0;
          try_cnt_q <= '0;
        end
        default: begin
        end
      endcase
    end else if (commit) begin
      pos_q <= pos_d;
      if (hit_q && hit_cnt_q != rmsp_pkg::COUNT_MAX) begin
        hit_cnt_q <= hit_cnt_q + CntW'(1);
      end
      if (try_cnt_q != rmsp_pkg::COUNT_MAX) begin
        try_cnt_q <= try_cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      pred_q <= pred;
      hit_q  <= (actual_base_i == pred);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_pred_q  <= pred_q;
      out_prob_q  <= prob_ext[ProbW-1:0];
      out_other_q <= other_ext[OthW-1:0];
      out_hit_q   <= hit_q;
      out_pos_q   <= pos_ext[PosOW-1:0];
    end
  end

  assign cfg_ready_o             = 1'b1;
  assign in_ready_o              = in_ready;
  assign out_valid_o             = out_valid_q;
  assign predicted_base_o        = out_pred_q;
  assign predicted_probability_o = out_prob_q;
  assign other_probability_o     = out_other_q;
  assign hit_o                   = out_hit_q;
  assign next_position_o         = out_pos_q;

endmodule

[bench/rmsp_checker.sv]
`timescale 1ns / 100ps
// Checker for the repeat model symbol predictor: models the state and compares result words.
module rmsp_checker #(
  parameter int ADDR_WIDTH = 32,
  parameter int PROB_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rmsp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [rmsp_pkg::BASE_W-1:0]     reference_base_i,
  input  logic [rmsp_pkg::BASE_W-1:0]     actual_base_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [rmsp_pkg::BASE_W-1:0]     predicted_base_i,
  input  logic [rmsp_pkg::PROB_W-1:0]     predicted_probability_i,
  input  logic [rmsp_pkg::OTHER_W-1:0]    other_probability_i,
  input  logic                            hit_i,
  input  logic [rmsp_pkg::POS_OUT_W-1:0]  next_position_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);

  localparam int ProbW  = rmsp_pkg::PROB_W;
  localparam int OthW   = rmsp_pkg::OTHER_W;
  localparam int PosOW  = rmsp_pkg::POS_OUT_W;
  localparam int AlphaW = rmsp_pkg::ALPHA_W;
  localparam int CntW   = rmsp_pkg::CNT_W;
  localparam int BaseW  = rmsp_pkg::BASE_W;

  typedef struct packed {
    logic [BaseW-1:0] base;
    logic [ProbW-1:0] prob;
    logic [OthW-1:0]  other;
    logic             hit;
    logic [PosOW-1:0] pos;
  } result_t;

  logic                  rev_mode;
  logic [AlphaW-1:0]     alpha;
  logic [ADDR_WIDTH-1:0] position;
  logic [CntW-1:0]       hits;
  logic [CntW-1:0]       tries;
  result_t               expected_q[$];
  int unsigned           mismatches = 0;

  assign errors_o = mismatches;

  function automatic logic [ProbW-1:0] smoothed_prob(input logic [CntW-1:0] h,
                                                     input logic [CntW-1:0] t,
                                                     input logic [AlphaW-1:0] a);
    logic [63:0] num;
    logic [63:0] den;
    num = {24'd0, h, 8'd0} + {48'd0, a};
    den = {24'd0, t, 8'd0} + ({48'd0, a} << 1);
    if (den == 64'd0) return ProbW'(64'd1 << (PROB_BITS - 1));
    if (num >= den) return ProbW'((64'd1 << PROB_BITS) - 64'd1);
    return ProbW'((num << PROB_BITS) / den);
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t: %s is %0h, predicted %0h", $time, field, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t          want;
    result_t          got;
    logic [BaseW-1:0] pred;
    if (!rst_ni) begin
      rev_mode = 1'b0;
      alpha    = rmsp_pkg::ALPHA_RESET;
      position = '0;
      hits     = '0;
      tries    = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rmsp_pkg::CFG_REVERSE: rev_mode = cfg_data_i[0];
          rmsp_pkg::CFG_ALPHA:   alpha = cfg_data_i[AlphaW-1:0];
          rmsp_pkg::CFG_START: begin
            position = ADDR_WIDTH'(cfg_data_i);
            hits     = '0;
            tries    = '0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pred       = rev_mode ? rmsp_pkg::BASE_MAX - reference_base_i : reference_base_i;
        want.base  = pred;
        want.prob  = smoothed_prob(hits, tries, alpha);
        want.other = OthW'(((32'd1 << PROB_BITS) - 32'(want.prob)) / 32'd3);
        want.hit   = (actual_base_i == pred);
        if (want.hit && hits != rmsp_pkg::COUNT_MAX) hits++;
        if (tries != rmsp_pkg::COUNT_MAX) tries++;
        position = rev_mode ? position - ADDR_WIDTH'(1) : position + ADDR_WIDTH'(1);
        want.pos = PosOW'(position);
        expected_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = '{predicted_base_i, predicted_probability_i, other_probability_i, hit_i,
                next_position_i};
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word", 64'(got), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.base != want.base) begin
            report_mismatch("predicted_base", 64'(got.base), 64'(want.base));
          end
          if (got.prob != want.prob) begin
            report_mismatch("predicted_probability", 64'(got.prob), 64'(want.prob));
          end
          if (got.other != want.other) begin
            report_mismatch("other_probability", 64'(got.other), 64'(want.other));
          end
          if (got.hit != want.hit) begin
            report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          end
          if (got.pos != want.pos) begin
            report_mismatch("next_position", 64'(got.pos), 64'(want.pos));
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

[bench/tb_repeat_model_symbol_predictor_core.sv]
`timescale 1ns / 100ps
// Testbench top for the repeat model symbol predictor: clock, reset, stimulus and verdict.
module tb_repeat_model_symbol_predictor_core;

  localparam int BaseW  = rmsp_pkg::BASE_W;
  localparam int AlphaW = rmsp_pkg::ALPHA_W;
  localparam logic [rmsp_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_WORDS   = 115;

  typedef enum logic [1:0] {
    STG_DIRECTED,
    STG_RANDOM,
    STG_CALM
  } run_stage_e;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [rmsp_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [rmsp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [BaseW-1:0]                reference_base_i = '0;
  logic [BaseW-1:0]                actual_base_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [BaseW-1:0]                predicted_base_o;
  logic [rmsp_pkg::PROB_W-1:0]     predicted_probability_o;
  logic [rmsp_pkg::OTHER_W-1:0]    other_probability_o;
  logic                            hit_o;
  logic [rmsp_pkg::POS_OUT_W-1:0]  next_position_o;

  int unsigned pending_words;
  int unsigned mismatch_total;
  run_stage_e  stage = STG_DIRECTED;
  logic        rev_now = 1'b0;
  logic        held_long = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  repeat_model_symbol_predictor_core DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .reference_base_i       (reference_base_i),
    .actual_base_i          (actual_base_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .predicted_base_o       (predicted_base_o),
    .predicted_probability_o(predicted_probability_o),
    .other_probability_o    (other_probability_o),
    .hit_o                  (hit_o),
    .next_position_o        (next_position_o)
  );

  rmsp_checker u_checker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_i            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_ready_i             (in_ready_o),
    .reference_base_i       (reference_base_i),
    .actual_base_i          (actual_base_i),
    .out_valid_i            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .predicted_base_i       (predicted_base_o),
    .predicted_probability_i(predicted_probability_o),
    .other_probability_i    (other_probability_o),
    .hit_i                  (hit_o),
    .next_position_i        (next_position_o),
    .pending_o              (pending_words),
    .errors_o               (mismatch_total)
  );

  task automatic cfg_write(input logic [rmsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rmsp_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic [BaseW-1:0] ref_b, input logic [BaseW-1:0] act_b);
    int gap;
    gap = 0;
    if (stage != STG_CALM && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    reference_base_i <= ref_b;
    actual_base_i    <= act_b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  task automatic random_word();
    logic [BaseW-1:0] ref_b;
    logic [BaseW-1:0] act_b;
    ref_b = BaseW'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 7) act_b = rev_now ? rmsp_pkg::BASE_MAX - ref_b : ref_b;
    else act_b = BaseW'($urandom_range(0, 3));
    send_word(ref_b, act_b);
  endtask

  task automatic random_config();
    logic [rmsp_pkg::CFG_DATA_W-1:0] data;
    rev_now = 1'($urandom_range(0, 1));
    data = $urandom;
    data[0] = rev_now;
    cfg_write(rmsp_pkg::CFG_REVERSE, data);
    data = $urandom;
    case ($urandom_range(0, 5))
      0: data[AlphaW-1:0] = '0;
      1: data[AlphaW-1:0] = 16'd1;
      2: data[AlphaW-1:0] = 16'hFFFF;
      3: data[AlphaW-1:0] = rmsp_pkg::ALPHA_RESET;
      default: data[AlphaW-1:0] = AlphaW'($urandom_range(1, 65535));
    endcase
    cfg_write(rmsp_pkg::CFG_ALPHA, data);
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_NONE, $urandom);
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 3))
        0: data = '0;
        1: data = 32'hFFFF_FFFF;
        2: data = rev_now ? 32'd40 : 32'hFFFF_FFC0;
        default: data = $urandom;
      endcase
      cfg_write(rmsp_pkg::CFG_START, data);
    end
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stage == STG_CALM) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if (stage == STG_RANDOM && !held_long) begin
        out_ready_i <= 1'b0;
        held_long = 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
        if ($urandom_range(0, 2) == 0) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int b = 0; b < 4; b++) send_word(BaseW'(b), BaseW'(b));
    send_word(2'd0, 2'd3);
    send_word(2'd3, 2'd0);
    drain_words();

    cfg_write(rmsp_pkg::CFG_REVERSE, 32'd1);
    cfg_write(rmsp_pkg::CFG_ALPHA, 32'h0000_FFFF);
    cfg_write(rmsp_pkg::CFG_START, 32'd0);
    rev_now = 1'b1;
    send_word(2'd0, 2'd3);
    send_word(2'd3, 2'd0);
    send_word(2'd1, 2'd1);
    send_word(2'd2, 2'd1);
    drain_words();

    cfg_write(rmsp_pkg::CFG_REVERSE, 32'hFFFF_FFFE);
    cfg_write(rmsp_pkg::CFG_ALPHA, 32'hFFFF_0000);
    cfg_write(rmsp_pkg::CFG_START, 32'hFFFF_FFFF);
    rev_now = 1'b0;
    send_word(2'd2, 2'd2);
    send_word(2'd1, 2'd1);
    send_word(2'd0, 2'd0);
    send_word(2'd3, 2'd1);
    send_word(2'd3, 2'd3);
    drain_words();

    cfg_write(CFG_NONE, 32'hFFFF_FFFF);
    cfg_write(rmsp_pkg::CFG_ALPHA, 32'd1);
    send_word(2'd1, 2'd1);
    send_word(2'd2, 2'd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_words();
      if (ph == 0) stage = STG_RANDOM;
      if (ph == RANDOM_PHASES - 1) stage = STG_CALM;
      random_config();
      repeat (PHASE_WORDS) random_word();
    end
    drain_words();
    repeat (40) @(posedge clk_i);

    if (mismatch_total == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
